// ===== sv/lme_pkg.sv =====
package lme_pkg;

  localparam int WINDOW_W = 24;
  localparam int MARK_W   = 16;
  localparam int BYTE_W   = 8;
  localparam int NCH      = 3;

  localparam logic [MARK_W-1:0] STOP_CODE = 16'hFFFE;
  localparam logic [4:0]        COUNT_SAT = 5'd24;
  localparam logic [4:0]        CHECK_MIN = 5'd17;

  // queue between front and back
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QLVL_W  = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    KIND_BYTE      = 2'd0,
    KIND_FINAL     = 2'd1,
    KIND_NOT_FOUND = 2'd2
  } kind_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    kind_t             kind;
  } res_t;

  // results of one pixel; two set means both slots are used
  typedef struct packed {
    logic       two;
    res_t [1:0] res;
  } job_t;

endpackage

// ===== sv/lme_pixel_if.sv =====
interface lme_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_level;
  logic [7:0] green_level;
  logic [7:0] blue_level;
  logic       start_of_image;
  logic       end_of_image;

  modport source (
    output valid, red_level, green_level, blue_level, start_of_image, end_of_image,
    input  ready
  );
  modport sink (
    input  valid, red_level, green_level, blue_level, start_of_image, end_of_image,
    output ready
  );
endinterface

// ===== sv/lme_result_if.sv =====
interface lme_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [1:0] result_kind;
  logic       last_of_run;

  modport source (
    output valid, data_byte, result_kind, last_of_run,
    input  ready
  );
  modport sink (
    input  valid, data_byte, result_kind, last_of_run,
    output ready
  );
endinterface

// ===== sv/lme_front.sv =====
module lme_front (
  input  logic          clk,
  input  logic          rst,
  lme_pixel_if.sink     pixel,
  output logic          push_valid,
  input  logic          push_ready,
  output lme_pkg::job_t push_job
);
  import lme_pkg::*;

  logic [WINDOW_W-1:0] window, window_next;
  logic [4:0]          count, count_next;
  logic [2:0]          phase, phase_next;
  logic                done, done_next;
  logic [1:0]          n;
  logic [NCH-1:0]      lsb;
  logic [BYTE_W-1:0]   mask;
  job_t                job;
  logic                accept;

  assign lsb    = {pixel.blue_level[0], pixel.green_level[0], pixel.red_level[0]};
  assign accept = pixel.valid && pixel.ready;

  always_comb begin
    window_next = window;
    count_next  = count;
    phase_next  = phase;
    done_next   = done;
    n           = 2'd0;
    mask        = '0;
    job         = '0;
    if (pixel.start_of_image) begin
      window_next = '0;
      count_next  = '0;
      phase_next  = '0;
      done_next   = 1'b0;
    end
    for (int ch = 0; ch < NCH; ch++) begin
      if (!done_next) begin
        window_next = {window_next[WINDOW_W-2:0], lsb[ch]};
        if (count_next < COUNT_SAT) count_next = count_next + 5'd1;
        phase_next = phase_next + 3'd1;
        if (count_next >= CHECK_MIN && window_next[MARK_W-1:0] == STOP_CODE) begin
          // leftover bits: phase, or a full byte on phase zero
          mask = 8'hFF >> (3'd0 - phase_next);
          job.res[n[0]].data = window_next[WINDOW_W-1:MARK_W] & mask;
          job.res[n[0]].kind = KIND_FINAL;
          n         = n + 2'd1;
          done_next = 1'b1;
        end else if (count_next == COUNT_SAT && phase_next == 3'd0) begin
          job.res[n[0]].data = window_next[WINDOW_W-1:MARK_W];
          job.res[n[0]].kind = KIND_BYTE;
          n = n + 2'd1;
        end
      end
    end
    if (pixel.end_of_image && !done_next) begin
      job.res[n[0]].data = '0;
      job.res[n[0]].kind = KIND_NOT_FOUND;
      n         = n + 2'd1;
      done_next = 1'b1;
    end
    job.two = n[1];
  end

  assign pixel.ready = push_ready;
  assign push_valid  = pixel.valid && (n != 2'd0);
  assign push_job    = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
      count  <= '0;
      phase  <= '0;
      done   <= 1'b0;
    end else if (accept) begin
      window <= window_next;
      count  <= count_next;
      phase  <= phase_next;
      done   <= done_next;
    end
  end
endmodule

// ===== sv/lme_queue.sv =====
module lme_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push_valid,
  output logic                       push_ready,
  input  lme_pkg::job_t              push_job,
  output logic                       pop_valid,
  input  logic                       pop_ready,
  output lme_pkg::job_t              pop_job,
  output logic [lme_pkg::QLVL_W-1:0] level
);
  import lme_pkg::*;

  job_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic              push, pop;

  assign push_ready = (level != QLVL_W'(QDEPTH));
  assign pop_valid  = (level != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_job    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      level <= level + 1'b1;
      else if (pop && !push) level <= level - 1'b1;
    end
  end
endmodule

// ===== sv/lme_back.sv =====
module lme_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  lme_pkg::job_t pop_job,
  lme_result_if.source  message
);
  import lme_pkg::*;

  logic second;
  logic last;
  logic take;

  assign last                = !pop_job.two || second;
  assign take                = message.valid && message.ready;
  assign message.valid       = pop_valid;
  assign message.data_byte   = pop_job.res[second].data;
  assign message.result_kind = pop_job.res[second].kind;
  assign message.last_of_run = last;
  assign pop_ready           = message.ready && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      second <= 1'b0;
    end else if (take) begin
      second <= !last;
    end
  end
endmodule

// ===== sv/lsb_message_extractor_top.sv =====
// channel  | dir | fields
// pixel    | in  | red_level, green_level, blue_level, start_of_image, end_of_image
// message  | out | data_byte, result_kind, last_of_run
//
// One pixel a cycle while the queue has room; its bits are scanned in the accept
// cycle and 0 to 2 words queued. A pixel's first word enters the queue on accept and
// is offered from its head. A pixel with two words holds the output for the second; the
// 2-entry queue absorbs it unless the next pixel also queues a word, which fills the queue.
// Pixel ready drops only when the queue is full; message stalls back up through it.
// Synchronous reset clears search state and the queue; no clearing pass.
module lsb_message_extractor_top (
  input  logic         clk,
  input  logic         rst,
  lme_pixel_if.sink    pixel,
  lme_result_if.source message
);
  import lme_pkg::*;

  logic              push_valid, push_ready;
  logic              pop_valid, pop_ready;
  job_t              push_job, pop_job;
  logic [QLVL_W-1:0] level;

  lme_front u_front (
    .clk        (clk),
    .rst        (rst),
    .pixel      (pixel),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  lme_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job),
    .level      (level)
  );

  lme_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job),
    .message   (message)
  );

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    message.valid |-> message.result_kind != 2'd3)
    else $error("illegal result kind");

  a_notfound_last: assert property (@(posedge clk) disable iff (rst)
    (message.valid && message.result_kind == KIND_NOT_FOUND)
      |-> (message.last_of_run && message.data_byte == '0))
    else $error("not-found word must be last and zero");

  a_queue_fill: assert property (@(posedge clk) disable iff (rst)
    (push_valid && push_ready && !(pop_valid && pop_ready) && level == QLVL_W'(QDEPTH - 1))
      |=> !pixel.ready)
    else $error("queue full but pixel still accepted");
endmodule
